// File: rtl/swc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swc_pkg
// Types, code tables and conversion functions of the Shift-JIS width converter.
// ---------------------------------------------------------------------------
package swc_pkg;

    localparam int OptW      = 16;
    localparam int MaxRes    = 4;
    localparam int StateDepth = 1;

    localparam int OptHPunct  = 0;
    localparam int OptHDigit  = 1;
    localparam int OptHAlpha  = 2;
    localparam int OptHKpunct = 3;
    localparam int OptHKata   = 4;
    localparam int OptHHira   = 5;
    localparam int OptHSpace2 = 6;
    localparam int OptBslash  = 7;
    localparam int OptFPunct  = 8;
    localparam int OptFDigit  = 9;
    localparam int OptFAlpha  = 10;
    localparam int OptFKpunct = 11;
    localparam int OptFKata   = 12;
    localparam int OptFHira   = 13;
    localparam int OptFSpace  = 14;
    localparam int OptNoMerge = 15;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_KANA = 2'd1,
        PEND_LEAD = 2'd2
    } pend_t;

    typedef enum logic [2:0] {
        CTX_ASCII = 3'd0,
        CTX_HKANA = 3'd1,
        CTX_OTHER = 3'd2,
        CTX_HIRA  = 3'd3,
        CTX_KATA  = 3'd4
    } ctx_t;

    typedef struct packed {
        pend_t      kind;
        logic [7:0] held;
        ctx_t       ctx;
        logic       err;
    } st_t;

    localparam int StateW = $bits(st_t);

    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  b;
    } seq_t;

    typedef struct packed {
        seq_t seq;
        logic used;
    } rel_t;

    typedef struct packed {
        seq_t seq;
        st_t  st;
    } tb_t;

    typedef struct packed {
        seq_t seq;
        st_t  st;
        logic again;
    } tp_t;

    typedef struct packed {
        seq_t seq;
        logic is_end;
        logic err;
        st_t  st;
    } step_t;

    localparam logic [7:0] SymToFull [0:39] = '{
        8'h49,8'h68,8'h94,8'h90,8'h93,8'h95,8'h66,8'h69,8'h6a,8'h96,
        8'h7b,8'h43,8'h7c,8'h44,8'h5e,8'h46,8'h47,8'h83,8'h81,8'h84,
        8'h48,8'h97,8'h6d,8'h8f,8'h6e,8'h4f,8'h51,8'h65,8'h6f,8'h62,
        8'h70,8'h50,8'h42,8'h75,8'h76,8'h41,8'h45,8'h4a,8'h4b,8'h5f
    };

    localparam logic [7:0] SymToHalf [0:87] = '{
        8'h20,8'hA4,8'hA1,8'h2C,8'h2E,8'hA5,8'h3A,8'h3B,
        8'h3F,8'h21,8'hDE,8'hDF,8'h00,8'h00,8'h00,8'h5E,
        8'h7E,8'h5F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'hB0,8'h00,8'h00,8'h2F,8'h00,
        8'h00,8'h00,8'h7C,8'h00,8'h00,8'h60,8'h27,8'h00,
        8'h22,8'h28,8'h29,8'h00,8'h00,8'h5B,8'h5D,8'h7B,
        8'h7D,8'h00,8'h00,8'h00,8'h00,8'hA2,8'hA3,8'h00,
        8'h00,8'h00,8'h00,8'h2B,8'h2D,8'h00,8'h00,8'h00,
        8'h00,8'h3D,8'h00,8'h3C,8'h3E,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h24,8'h00,8'h00,8'h25,8'h23,8'h26,8'h2A,8'h40
    };

    localparam logic [7:0] KanaToFull [0:55] = '{
        8'h51,8'h00,8'h02,8'h04,8'h06,8'h08,8'h42,8'h44,8'h46,8'h22,8'h00,
        8'h01,8'h03,8'h85,8'h07,8'h09,8'h8a,8'h8c,8'h8e,8'h90,8'h92,
        8'h94,8'h96,8'h98,8'h9a,8'h9c,8'h9e,8'hA0,8'hA3,8'hA5,8'hA7,
        8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'hAe,8'hB1,8'hB4,8'hB7,8'hBa,
        8'h3d,8'h3e,8'h3f,8'h40,8'h41,8'h43,8'h45,8'h47,
        8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4e,8'h52
    };

    localparam logic [7:0] KanaToHalf [0:83] = '{
        8'h01,8'h0b,8'h02,8'h0c,8'h03,8'h0d,8'h04,8'h0e,8'h05,8'h0f,
        8'h10,8'h90,8'h11,8'h91,8'h12,8'h92,8'h13,8'h93,8'h14,8'h94,
        8'h15,8'h95,8'h16,8'h96,8'h17,8'h97,8'h18,8'h98,8'h19,8'h99,
        8'h1a,8'h9a,8'h1b,8'h9b,8'h09,8'h1c,8'h9c,8'h1d,8'h9d,8'h1e,8'h9e,
        8'h1f,8'h20,8'h21,8'h22,8'h23,
        8'h24,8'hA4,8'h64,8'h25,8'hA5,8'h65,8'h26,8'hA6,8'h66,
        8'h27,8'hA7,8'h67,8'h28,8'hA8,8'h68,
        8'h29,8'h2a,8'h2b,8'h2c,8'h2d,
        8'h06,8'h2e,8'h07,8'h2f,8'h08,8'h30,
        8'h31,8'h32,8'h33,8'h34,8'h35,
        8'hff,8'h36,8'hff,8'hff,8'h00,8'h37,8'h8d
    };

    function automatic seq_t mk0();
        seq_t s;
        s = '0;
        return s;
    endfunction

    function automatic seq_t mk1(input logic [7:0] a);
        seq_t s;
        s      = '0;
        s.n    = 3'd1;
        s.b[0] = a;
        return s;
    endfunction

    function automatic seq_t mk2(input logic [7:0] a, input logic [7:0] c);
        seq_t s;
        s      = '0;
        s.n    = 3'd2;
        s.b[0] = a;
        s.b[1] = c;
        return s;
    endfunction

    function automatic seq_t mk16(input logic [15:0] v);
        seq_t s;
        if (v[15:8] != 8'h00)
        begin
            s = mk2(v[15:8], v[7:0]);
        end
        else
        begin
            s = mk1(v[7:0]);
        end
        return s;
    endfunction

    function automatic seq_t app(input seq_t a, input seq_t x);
        seq_t s;
        s = a;
        for (int i = 0; i < MaxRes; i++)
        begin
            if (i < int'(x.n) && (int'(a.n) + i) < MaxRes)
            begin
                s.b[int'(a.n) + i] = x.b[i];
            end
        end
        if (int'(a.n) + int'(x.n) > MaxRes)
        begin
            s.n = 3'(MaxRes);
        end
        else
        begin
            s.n = a.n + x.n;
        end
        return s;
    endfunction

    function automatic logic [15:0] full_sym(input logic [5:0] idx);
        return {8'h81, SymToFull[idx]};
    endfunction

    function automatic rel_t release_kana(input logic [7:0] k, input logic [7:0] nb,
                                          input logic have_nb, input logic [OptW-1:0] opts);
        rel_t       r;
        logic [7:0] idx;
        logic [7:0] c;
        logic [7:0] d;
        logic       done;
        r    = '0;
        done = 1'b0;
        idx  = k - 8'hA6;
        c    = 8'h00;
        d    = 8'h00;
        if (!(opts[OptFKata] || opts[OptFHira]) || k < 8'hA6 || idx >= 8'd56)
        begin
            r.seq = mk1(k);
        end
        else
        begin
            c = KanaToFull[idx[5:0]];
            d = {1'b0, c[6:0]};
            if (have_nb && !opts[OptNoMerge])
            begin
                if (nb == 8'hDE && c[7])
                begin
                    if (k == 8'hB3)
                    begin
                        if (opts[OptFKata])
                        begin
                            r.seq  = mk16(16'h8394);
                            r.used = 1'b1;
                            done   = 1'b1;
                        end
                    end
                    else
                    begin
                        d      = d + 8'd1;
                        r.used = 1'b1;
                    end
                end
                else if (nb == 8'hDF && k >= 8'hCA && k <= 8'hCE)
                begin
                    d      = d + 8'd2;
                    r.used = 1'b1;
                end
            end
            if (!done)
            begin
                if (opts[OptFKata])
                begin
                    if (d > 8'h3E)
                    begin
                        d = d + 8'd1;
                    end
                    r.seq = mk16(16'h8340 + {8'h00, d});
                end
                else
                begin
                    r.seq = mk16(16'h829F + {8'h00, d});
                end
            end
        end
        return r;
    endfunction

    function automatic tb_t take_byte(input logic [7:0] b, input logic [OptW-1:0] opts,
                                      input st_t st_in);
        tb_t         t;
        logic [15:0] v;
        logic        sym_v;
        logic [7:0]  sym;
        logic        kana_on;
        logic        hold;
        t       = '0;
        t.st    = st_in;
        v       = {8'h00, b};
        sym_v   = 1'b0;
        sym     = 8'h00;
        hold    = 1'b0;
        kana_on = opts[OptFKata] || opts[OptFHira];
        if (b <= 8'h80)
        begin
            t.st.ctx = CTX_ASCII;
            if (b <= 8'h1F)
            begin
                v = {8'h00, b};
            end
            else if (b == 8'h20)
            begin
                if (opts[OptFSpace]) v = 16'h8140;
            end
            else if (b <= 8'h2F)
            begin
                sym_v = 1'b1;
                sym   = b - 8'h21;
            end
            else if (b <= 8'h39)
            begin
                if (opts[OptFDigit]) v = {8'h00, b} + 16'h821F;
            end
            else if (b <= 8'h40)
            begin
                sym_v = 1'b1;
                sym   = b - 8'h2B;
            end
            else if (b <= 8'h5A)
            begin
                if (opts[OptFAlpha]) v = {8'h00, b} + 16'h821F;
            end
            else if (b <= 8'h60)
            begin
                sym_v = 1'b1;
                sym   = (b == 8'h5C && opts[OptBslash]) ? 8'd39 : b - 8'h45;
            end
            else if (b <= 8'h7A)
            begin
                if (opts[OptFAlpha]) v = {8'h00, b} + 16'h8220;
            end
            else if (b <= 8'h7E)
            begin
                sym_v = 1'b1;
                sym   = b - 8'h5F;
            end
            if (sym_v && opts[OptFPunct])
            begin
                v = full_sym(sym[5:0]);
            end
        end
        else if (b <= 8'h9F || (b >= 8'hE0 && b <= 8'hFC))
        begin
            t.st.kind = PEND_LEAD;
            t.st.held = b;
            hold      = 1'b1;
        end
        else if (b == 8'hA0 || b >= 8'hFD)
        begin
            v = {8'h00, b};
        end
        else if (b <= 8'hA4)
        begin
            if (opts[OptFKpunct]) v = full_sym(6'(b - 8'hA1 + 8'd32));
        end
        else if (b == 8'hA5 || b == 8'hB0)
        begin
            if ((st_in.ctx == CTX_HKANA && kana_on) ||
                (st_in.ctx != CTX_HKANA && opts[OptFKpunct]))
            begin
                v = (b == 8'hA5) ? 16'h8145 : 16'h815B;
            end
        end
        else if (b <= 8'hDD)
        begin
            t.st.ctx = CTX_HKANA;
            if (kana_on)
            begin
                t.st.kind = PEND_KANA;
                t.st.held = b;
                hold      = 1'b1;
            end
        end
        else
        begin
            if ((st_in.ctx == CTX_HKANA && kana_on) || opts[OptFKpunct])
            begin
                v = full_sym(6'(b - 8'hDE + 8'd37));
            end
        end
        t.seq = hold ? mk0() : mk16(v);
        return t;
    endfunction

    function automatic seq_t half_kana(input logic [7:0] lead, input logic [7:0] c,
                                       input logic [6:0] d);
        seq_t       s;
        logic [7:0] e;
        e = KanaToHalf[d];
        if (e == 8'hFF)
        begin
            s = mk2(lead, c);
        end
        else
        begin
            s = mk1({2'b00, e[5:0]} + 8'hA6);
            if (e[7])
            begin
                s = app(s, mk1(8'hDE));
            end
            else if (e[6])
            begin
                s = app(s, mk1(8'hDF));
            end
        end
        return s;
    endfunction

    function automatic tp_t take_pair(input logic [7:0] lead, input logic [7:0] c,
                                      input logic [OptW-1:0] opts, input st_t st_in);
        tp_t        t;
        logic       pass;
        logic [7:0] h;
        logic [7:0] ci;
        logic [7:0] d;
        t    = '0;
        t.st = st_in;
        pass = 1'b1;
        ci   = c - 8'h40;
        h    = (c >= 8'h40 && c <= 8'h97) ? SymToHalf[ci[6:0]] : 8'h00;
        d    = 8'h00;
        if (!(c >= 8'h40 && c <= 8'hFC && c != 8'h7F))
        begin
            t.st.ctx = CTX_OTHER;
            t.st.err = 1'b1;
            t.again  = (c == 8'h09) || (c >= 8'h20 && c <= 8'h3F);
            pass     = 1'b0;
        end
        else if (lead == 8'h81)
        begin
            if (c == 8'h40 && opts[OptHSpace2])
            begin
                t.st.ctx = CTX_OTHER;
                t.seq    = mk2(8'h20, 8'h20);
                pass     = 1'b0;
            end
            else if (c == 8'h5B || c == 8'h4A || c == 8'h4B || c == 8'h45)
            begin
                if ((st_in.ctx == CTX_HIRA && opts[OptHHira]) ||
                    (st_in.ctx == CTX_KATA && opts[OptHKata]) ||
                    (st_in.ctx != CTX_HIRA && st_in.ctx != CTX_KATA && opts[OptHKpunct]))
                begin
                    t.seq = mk1(h);
                    pass  = 1'b0;
                end
            end
            else if (c == 8'h41 || c == 8'h42 || c == 8'h75 || c == 8'h76)
            begin
                if (opts[OptHKpunct])
                begin
                    t.seq = mk1(h);
                    pass  = 1'b0;
                end
            end
            else if (c <= 8'h97 && opts[OptHPunct])
            begin
                t.st.ctx = CTX_OTHER;
                if (opts[OptBslash] ? (c == 8'h5F) : (c == 8'h8F))
                begin
                    t.seq = mk1(8'h5C);
                    pass  = 1'b0;
                end
                else if (h != 8'h00)
                begin
                    t.seq = mk1(h);
                    pass  = 1'b0;
                end
            end
        end
        else if (lead == 8'h82)
        begin
            if (c >= 8'h4F && c <= 8'h58)
            begin
                t.st.ctx = CTX_OTHER;
                if (opts[OptHDigit])
                begin
                    t.seq = mk1(c - 8'h1F);
                    pass  = 1'b0;
                end
            end
            else if (c >= 8'h60 && c <= 8'h79)
            begin
                t.st.ctx = CTX_OTHER;
                if (opts[OptHAlpha])
                begin
                    t.seq = mk1(c - 8'h1F);
                    pass  = 1'b0;
                end
            end
            else if (c >= 8'h81 && c <= 8'h9A)
            begin
                t.st.ctx = CTX_OTHER;
                if (opts[OptHAlpha])
                begin
                    t.seq = mk1(c - 8'h20);
                    pass  = 1'b0;
                end
            end
            else
            begin
                t.st.ctx = CTX_HIRA;
                if (c >= 8'h9F && c <= 8'hF1 && opts[OptHHira])
                begin
                    d     = c - 8'h9F;
                    t.seq = half_kana(lead, c, d[6:0]);
                    pass  = 1'b0;
                end
            end
        end
        else if (lead == 8'h83)
        begin
            t.st.ctx = CTX_KATA;
            if (c <= 8'h94 && opts[OptHKata])
            begin
                d = c - 8'h40;
                if (d > 8'h3E)
                begin
                    d = d - 8'd1;
                end
                t.seq = half_kana(lead, c, d[6:0]);
                pass  = 1'b0;
            end
        end
        else
        begin
            t.st.ctx = CTX_OTHER;
        end
        if (pass)
        begin
            t.seq = mk2(lead, c);
        end
        return t;
    endfunction

    function automatic step_t step(input st_t st_in, input logic [7:0] b,
                                   input logic [OptW-1:0] opts);
        step_t r;
        st_t   s0;
        rel_t  rel;
        tb_t   tb;
        tp_t   tp;
        r       = '0;
        s0      = st_in;
        s0.kind = PEND_NONE;
        s0.held = 8'h00;
        rel     = release_kana(st_in.held, b, b != 8'h00, opts);
        tp      = take_pair(st_in.held, b, opts, s0);
        tb      = take_byte(b, opts, (st_in.kind == PEND_LEAD) ? tp.st : s0);
        r.st    = s0;
        if (b == 8'h00)
        begin
            r.seq    = (st_in.kind == PEND_KANA) ? app(rel.seq, mk1(8'h00)) : mk1(8'h00);
            r.is_end = 1'b1;
            r.err    = st_in.err;
            r.st.ctx = CTX_ASCII;
            r.st.err = 1'b0;
        end
        else if (st_in.kind == PEND_KANA)
        begin
            if (rel.used)
            begin
                r.seq = rel.seq;
            end
            else
            begin
                r.seq = app(rel.seq, tb.seq);
                r.st  = tb.st;
            end
        end
        else if (st_in.kind == PEND_LEAD)
        begin
            if (tp.again)
            begin
                r.seq = tb.seq;
                r.st  = tb.st;
            end
            else
            begin
                r.seq = tp.seq;
                r.st  = tp.st;
            end
        end
        else
        begin
            r.seq = tb.seq;
            r.st  = tb.st;
        end
        return r;
    endfunction

endpackage

// File: rtl/swc_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swc_if
// Valid/ready channels of the width converter: input, output, configuration.
// ---------------------------------------------------------------------------
interface swc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface swc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       string_end;
    logic       had_error;
    logic       last_of_run;
    modport source (output valid, output out_byte, output string_end, output had_error,
                    output last_of_run, input ready);
    modport sink (input valid, input out_byte, input string_end, input had_error,
                  input last_of_run, output ready);
endinterface

interface swc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] conversion_options;
    modport source (output valid, output conversion_options, input ready);
    modport sink (input valid, input conversion_options, output ready);
endinterface

// File: rtl/swc_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swc_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module swc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/sjis_width_converter_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sjis_width_converter_top
// Shift-JIS half-width / full-width converter, one source byte per word.
// ---------------------------------------------------------------------------
// Each source byte yields zero to four output words, sent one per cycle while
// dout.ready is high. A byte is taken every cycle as long as earlier bytes
// give at most one word each and output is not stalled; otherwise a byte waits
// in s1_byte_reg until the last word before it is sent. The converter state
// (pending byte, script context, error flag) sits in a one-entry RAM and is
// read, updated and written back once per byte, with the last written value
// forwarded. Write conversion_options only when idle.
module sjis_width_converter_top
    import swc_pkg::*;
#(
    parameter int STATE_DEPTH = StateDepth
) (
    input  logic      clk,
    input  logic      rst_n,
    swc_cfg_if.sink   cfg,
    swc_in_if.sink    din,
    swc_out_if.source dout
);

    localparam int AW = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;

    logic [OptW-1:0]  opts_reg;
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             init_reg;
    logic             fwd_reg;
    st_t              fwd_st_reg;
    logic [2:0]       cnt_reg;
    logic [2:0]       idx_reg;
    logic [3:0][7:0]  buf_reg;
    logic             end_reg;
    logic             err_reg;

    logic [StateW-1:0] ram_rdata;
    st_t               st_cur;
    step_t             res;
    logic              out_fire;
    logic              buf_free;
    logic              s1_go;
    logic              is_last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opts_reg <= '0;
        end
        else if (cfg.valid)
        begin
            opts_reg <= cfg.conversion_options;
        end
    end

    swc_ram #(
        .WIDTH (StateW),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_go),
        .addr  (AW'(0)),
        .wdata (res.st),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (!init_reg)
        begin
            st_cur = '0;
        end
        else if (fwd_reg)
        begin
            st_cur = fwd_st_reg;
        end
        else
        begin
            st_cur = st_t'(ram_rdata);
        end
    end

    assign res      = step(st_cur, s1_byte_reg, opts_reg);
    assign is_last  = (idx_reg + 3'd1) == cnt_reg;
    assign out_fire = dout.valid && dout.ready;
    assign buf_free = (idx_reg == cnt_reg) || (out_fire && is_last);
    assign s1_go    = s1_valid_reg && buf_free;
    assign din.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            init_reg     <= 1'b0;
            fwd_reg      <= 1'b0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (din.valid && din.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            fwd_reg <= s1_go;
            if (s1_go)
            begin
                init_reg <= 1'b1;
                cnt_reg  <= res.seq.n;
                idx_reg  <= '0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            s1_byte_reg <= din.in_byte;
        end
        if (s1_go)
        begin
            fwd_st_reg <= res.st;
            buf_reg    <= res.seq.b;
            end_reg    <= res.is_end;
            err_reg    <= res.err;
        end
    end

    assign dout.valid       = idx_reg < cnt_reg;
    assign dout.out_byte    = buf_reg[idx_reg[1:0]];
    assign dout.last_of_run = is_last;
    assign dout.string_end  = end_reg && is_last;
    assign dout.had_error   = end_reg && is_last && err_reg;

endmodule

// File: rtl/swc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swc_checker
// Port-level checks of the width converter output channel.
// ---------------------------------------------------------------------------
module swc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       string_end,
    input logic       had_error,
    input logic       last_of_run
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output word changed while stalled");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> last_of_run)
        else $error("terminator not last word of its run");

    a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && had_error |-> string_end)
        else $error("error flag without terminator");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> out_byte == 8'h00)
        else $error("terminator word not zero");

endmodule

bind sjis_width_converter_top swc_checker u_swc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .out_byte    (dout.out_byte),
    .string_end  (dout.string_end),
    .had_error   (dout.had_error),
    .last_of_run (dout.last_of_run)
);

// File: dv/swc_tb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swc_tb_if
// Stall interface used by the width converter test. The block's own channel
// interfaces come from the RTL; this file only holds the output hold-off flag.
// ---------------------------------------------------------------------------
interface swc_stall_if;
    logic hold_long;
endinterface

// File: dv/sjis_width_converter_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sjis_width_converter_top_test
// Checks the Shift-JIS width converter against its own predictor of the
// conversion: directed strings for each class, then random strings under
// several option settings, with bursty input, stalled output and a long
// output hold-off that fills the block.
// ---------------------------------------------------------------------------
module sjis_width_converter_top_test;
    import swc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       string_end;
        logic       had_error;
        logic       last_of_run;
    } word_t;

    logic clk;
    logic rst_n;

    swc_cfg_if cfg ();
    swc_in_if din ();
    swc_out_if dout ();
    swc_stall_if stall ();

    sjis_width_converter_top dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg.sink),
        .din  (din.sink),
        .dout (dout.source)
    );

    logic [15:0] opts_q;
    pend_t       pend_q;
    logic [7:0]  held_q;
    ctx_t        ctx_q;
    logic        err_q;
    word_t       expected_words[$];
    int          mismatches;
    longint      cycles = 0;
    bit          timed_out;
    int          burst_left;

    logic [7:0] to_full_tab [0:39] = '{
        8'h49,8'h68,8'h94,8'h90,8'h93,8'h95,8'h66,8'h69,8'h6a,8'h96,
        8'h7b,8'h43,8'h7c,8'h44,8'h5e,8'h46,8'h47,8'h83,8'h81,8'h84,
        8'h48,8'h97,8'h6d,8'h8f,8'h6e,8'h4f,8'h51,8'h65,8'h6f,8'h62,
        8'h70,8'h50,8'h42,8'h75,8'h76,8'h41,8'h45,8'h4a,8'h4b,8'h5f
    };
    logic [7:0] to_half_tab [0:87] = '{
        8'h20,8'hA4,8'hA1,8'h2C,8'h2E,8'hA5,8'h3A,8'h3B,8'h3F,8'h21,8'hDE,8'hDF,
        8'h00,8'h00,8'h00,8'h5E,8'h7E,8'h5F,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'hB0,8'h00,8'h00,8'h2F,8'h00,8'h00,8'h00,8'h7C,8'h00,
        8'h00,8'h60,8'h27,8'h00,8'h22,8'h28,8'h29,8'h00,8'h00,8'h5B,8'h5D,8'h7B,
        8'h7D,8'h00,8'h00,8'h00,8'h00,8'hA2,8'hA3,8'h00,8'h00,8'h00,8'h00,8'h2B,
        8'h2D,8'h00,8'h00,8'h00,8'h00,8'h3D,8'h00,8'h3C,8'h3E,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h24,8'h00,8'h00,8'h25,
        8'h23,8'h26,8'h2A,8'h40
    };
    logic [7:0] kana_full_tab [0:55] = '{
        8'h51,8'h00,8'h02,8'h04,8'h06,8'h08,8'h42,8'h44,8'h46,8'h22,8'h00,
        8'h01,8'h03,8'h85,8'h07,8'h09,8'h8a,8'h8c,8'h8e,8'h90,8'h92,
        8'h94,8'h96,8'h98,8'h9a,8'h9c,8'h9e,8'hA0,8'hA3,8'hA5,8'hA7,
        8'h29,8'h2a,8'h2b,8'h2c,8'h2d,8'hAe,8'hB1,8'hB4,8'hB7,8'hBa,
        8'h3d,8'h3e,8'h3f,8'h40,8'h41,8'h43,8'h45,8'h47,
        8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4e,8'h52
    };
    logic [7:0] kana_half_tab [0:83] = '{
        8'h01,8'h0b,8'h02,8'h0c,8'h03,8'h0d,8'h04,8'h0e,8'h05,8'h0f,
        8'h10,8'h90,8'h11,8'h91,8'h12,8'h92,8'h13,8'h93,8'h14,8'h94,
        8'h15,8'h95,8'h16,8'h96,8'h17,8'h97,8'h18,8'h98,8'h19,8'h99,
        8'h1a,8'h9a,8'h1b,8'h9b,8'h09,8'h1c,8'h9c,8'h1d,8'h9d,8'h1e,8'h9e,
        8'h1f,8'h20,8'h21,8'h22,8'h23,
        8'h24,8'hA4,8'h64,8'h25,8'hA5,8'h65,8'h26,8'hA6,8'h66,
        8'h27,8'hA7,8'h67,8'h28,8'hA8,8'h68,
        8'h29,8'h2a,8'h2b,8'h2c,8'h2d,
        8'h06,8'h2e,8'h07,8'h2f,8'h08,8'h30,
        8'h31,8'h32,8'h33,8'h34,8'h35,
        8'hff,8'h36,8'hff,8'hff,8'h00,8'h37,8'h8d
    };

    word_t step_words[$];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void push_word(input logic [7:0] b, input logic is_end);
        word_t w;
        if (step_words.size() >= MaxRes)
        begin
            return;
        end
        w.out_byte    = b;
        w.string_end  = is_end;
        w.had_error   = is_end ? err_q : 1'b0;
        w.last_of_run = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void push_code(input logic [15:0] v);
        if (v[15:8] != 8'h00)
        begin
            push_word(v[15:8], 1'b0);
        end
        push_word(v[7:0], 1'b0);
    endfunction

    function automatic logic [15:0] full_symbol(input int idx);
        return {8'h81, to_full_tab[idx % 40]};
    endfunction

    function automatic bit widen_kana(input logic [7:0] k, input logic [7:0] nb,
                                      input bit have_nb);
        int         idx;
        logic [7:0] c;
        int         d;
        bit         merged;
        idx    = int'(k) - 'hA6;
        merged = 1'b0;
        if (!(opts_q[OptFKata] || opts_q[OptFHira]) || k < 8'hA6 || idx >= 56)
        begin
            push_word(k, 1'b0);
            return 1'b0;
        end
        c = kana_full_tab[idx];
        d = c[6:0];
        if (have_nb && !opts_q[OptNoMerge])
        begin
            if (nb == 8'hDE && c[7])
            begin
                if (k == 8'hB3)
                begin
                    if (opts_q[OptFKata])
                    begin
                        push_code(16'h8394);
                        return 1'b1;
                    end
                end
                else
                begin
                    d++;
                    merged = 1'b1;
                end
            end
            else if (nb == 8'hDF && k >= 8'hCA && k <= 8'hCE)
            begin
                d += 2;
                merged = 1'b1;
            end
        end
        if (opts_q[OptFKata])
        begin
            if (d > 'h3E)
            begin
                d++;
            end
            push_code(16'(16'h8340 + d));
        end
        else
        begin
            push_code(16'(16'h829F + d));
        end
        return merged;
    endfunction

    function automatic void widen_byte(input logic [7:0] b);
        logic [15:0] v;
        int          sym;
        bit          kana_on;
        v       = {8'h00, b};
        sym     = -1;
        kana_on = opts_q[OptFKata] || opts_q[OptFHira];
        if (b <= 8'h80)
        begin
            ctx_q = CTX_ASCII;
            if (b <= 8'h1F)
            begin
            end
            else if (b == 8'h20)
            begin
                if (opts_q[OptFSpace]) v = 16'h8140;
            end
            else if (b <= 8'h2F) sym = b - 'h21;
            else if (b <= 8'h39)
            begin
                if (opts_q[OptFDigit]) v = 16'(b + 'h824F - 'h30);
            end
            else if (b <= 8'h40) sym = b - 'h2B;
            else if (b <= 8'h5A)
            begin
                if (opts_q[OptFAlpha]) v = 16'(b + 'h825F - 'h40);
            end
            else if (b <= 8'h60) sym = (b == 8'h5C && opts_q[OptBslash]) ? 39 : b - 'h45;
            else if (b <= 8'h7A)
            begin
                if (opts_q[OptFAlpha]) v = 16'(b + 'h8280 - 'h60);
            end
            else if (b <= 8'h7E) sym = b - 'h5F;
            if (sym >= 0 && opts_q[OptFPunct]) v = full_symbol(sym);
        end
        else if (b <= 8'h9F || (b >= 8'hE0 && b <= 8'hFC))
        begin
            pend_q = PEND_LEAD;
            held_q = b;
            return;
        end
        else if (b == 8'hA0 || b >= 8'hFD)
        begin
        end
        else if (b <= 8'hA4)
        begin
            if (opts_q[OptFKpunct]) v = full_symbol(b - 'hA1 + 32);
        end
        else if (b == 8'hA5 || b == 8'hB0)
        begin
            if ((ctx_q == CTX_HKANA && kana_on) || (ctx_q != CTX_HKANA && opts_q[OptFKpunct]))
                v = (b == 8'hA5) ? 16'h8145 : 16'h815B;
        end
        else if (b <= 8'hDD)
        begin
            ctx_q = CTX_HKANA;
            if (kana_on)
            begin
                pend_q = PEND_KANA;
                held_q = b;
                return;
            end
        end
        else
        begin
            if ((ctx_q == CTX_HKANA && kana_on) || opts_q[OptFKpunct])
                v = full_symbol(b - 'hDE + 37);
        end
        push_code(v);
    endfunction

    function automatic void narrow_kana(input logic [7:0] lead, input logic [7:0] c,
                                        input int d);
        logic [7:0] e;
        e = kana_half_tab[d % 84];
        if (e == 8'hFF)
        begin
            push_word(lead, 1'b0);
            push_word(c, 1'b0);
            return;
        end
        push_word(8'({2'b00, e[5:0]} + 8'hA6), 1'b0);
        if (e[7]) push_word(8'hDE, 1'b0);
        else if (e[6]) push_word(8'hDF, 1'b0);
    endfunction

    function automatic bit narrow_pair(input logic [7:0] lead, input logic [7:0] c);
        bit         keep;
        logic [7:0] h;
        int         d;
        ctx_t       f;
        keep = 1'b1;
        if (!(c >= 8'h40 && c <= 8'hFC && c != 8'h7F))
        begin
            ctx_q = CTX_OTHER;
            err_q = 1'b1;
            return c == 8'h09 || (c >= 8'h20 && c <= 8'h3F);
        end
        if (lead == 8'h81)
        begin
            h = (c <= 8'h97) ? to_half_tab[c - 'h40] : 8'h00;
            if (c == 8'h40 && opts_q[OptHSpace2])
            begin
                ctx_q = CTX_OTHER;
                push_word(8'h20, 1'b0);
                push_word(8'h20, 1'b0);
                keep = 1'b0;
            end
            else if (c == 8'h5B || c == 8'h4A || c == 8'h4B || c == 8'h45)
            begin
                f = ctx_q;
                if ((f == CTX_HIRA && opts_q[OptHHira]) || (f == CTX_KATA && opts_q[OptHKata])
                    || (f != CTX_HIRA && f != CTX_KATA && opts_q[OptHKpunct]))
                begin
                    push_word(h, 1'b0);
                    keep = 1'b0;
                end
            end
            else if (c == 8'h41 || c == 8'h42 || c == 8'h75 || c == 8'h76)
            begin
                if (opts_q[OptHKpunct])
                begin
                    push_word(h, 1'b0);
                    keep = 1'b0;
                end
            end
            else if (c <= 8'h97 && opts_q[OptHPunct])
            begin
                ctx_q = CTX_OTHER;
                if (opts_q[OptBslash] ? (c == 8'h5F) : (c == 8'h8F))
                begin
                    push_word(8'h5C, 1'b0);
                    keep = 1'b0;
                end
                else if (h != 8'h00)
                begin
                    push_word(h, 1'b0);
                    keep = 1'b0;
                end
            end
        end
        else if (lead == 8'h82)
        begin
            if (c >= 8'h4F && c <= 8'h58)
            begin
                ctx_q = CTX_OTHER;
                if (opts_q[OptHDigit])
                begin
                    push_word(8'(c - 'h4F + 'h30), 1'b0);
                    keep = 1'b0;
                end
            end
            else if (c >= 8'h60 && c <= 8'h79)
            begin
                ctx_q = CTX_OTHER;
                if (opts_q[OptHAlpha])
                begin
                    push_word(8'(c - 'h60 + 'h41), 1'b0);
                    keep = 1'b0;
                end
            end
            else if (c >= 8'h81 && c <= 8'h9A)
            begin
                ctx_q = CTX_OTHER;
                if (opts_q[OptHAlpha])
                begin
                    push_word(8'(c - 'h81 + 'h61), 1'b0);
                    keep = 1'b0;
                end
            end
            else
            begin
                ctx_q = CTX_HIRA;
                if (c >= 8'h9F && c <= 8'hF1 && opts_q[OptHHira])
                begin
                    narrow_kana(lead, c, c - 'h9F);
                    keep = 1'b0;
                end
            end
        end
        else if (lead == 8'h83)
        begin
            ctx_q = CTX_KATA;
            if (c <= 8'h94 && opts_q[OptHKata])
            begin
                d = c - 'h40;
                if (d > 'h3E) d--;
                narrow_kana(lead, c, d);
                keep = 1'b0;
            end
        end
        else
        begin
            ctx_q = CTX_OTHER;
        end
        if (keep)
        begin
            push_word(lead, 1'b0);
            push_word(c, 1'b0);
        end
        return 1'b0;
    endfunction

    function automatic void convert_byte(input logic [7:0] b);
        pend_t      kind;
        logic [7:0] held;
        kind   = pend_q;
        held   = held_q;
        pend_q = PEND_NONE;
        held_q = 8'h00;
        step_words.delete();
        if (b == 8'h00)
        begin
            if (kind == PEND_KANA) void'(widen_kana(held, 8'h00, 1'b0));
            push_word(8'h00, 1'b1);
            ctx_q = CTX_ASCII;
            err_q = 1'b0;
        end
        else if (kind == PEND_KANA)
        begin
            if (!widen_kana(held, b, 1'b1)) widen_byte(b);
        end
        else if (kind == PEND_LEAD)
        begin
            if (narrow_pair(held, b)) widen_byte(b);
        end
        else
        begin
            widen_byte(b);
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
        foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(4, 0);
            if (gap > 0)
            begin
                din.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        din.valid   <= 1'b1;
        din.in_byte <= b;
        @(posedge clk);
        while (!din.ready) @(posedge clk);
        convert_byte(b);
        burst_left--;
    endtask

    task automatic drain();
        din.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_options(input logic [15:0] v);
        drain();
        cfg.valid              <= 1'b1;
        cfg.conversion_options <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        opts_q = v;
    endtask

    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[i]) send_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9, 0))
            0, 1: return 8'($urandom_range('h7E, 'h20));
            2, 3: return 8'($urandom_range('hDF, 'hA1));
            4: return 8'($urandom_range(255, 1));
            default: return 8'h00;
        endcase
    endfunction

    task automatic test_directed_widen();
        write_options(16'hFF00);
        send_string('{8'h20, 8'h21, 8'h30, 8'h39, 8'h41, 8'h5C, 8'h7A, 8'h7E, 8'hA1,
                      8'hB6, 8'hDE, 8'hCA, 8'hDF, 8'hB3, 8'hDE, 8'hA5, 8'hB0, 8'hB1,
                      8'h00});
        write_options(16'h3000);
        send_string('{8'hB3, 8'hDE, 8'hB6, 8'h00});
        write_options(16'h2000);
        send_string('{8'hB3, 8'hDE, 8'hCA});
        write_options(16'h0000);
        send_string('{8'h00, 8'h80, 8'hA0, 8'hFF, 8'h7F, 8'h01, 8'h00});
    endtask

    task automatic test_directed_narrow();
        write_options(16'h00FF);
        send_string('{8'h81, 8'h40, 8'h81, 8'h5B, 8'h82, 8'h4F, 8'h82, 8'h60, 8'h82,
                      8'h81, 8'h82, 8'hAA, 8'h83, 8'h94, 8'h83, 8'h8E, 8'h81, 8'h5F,
                      8'h81, 8'h41, 8'hE0, 8'h40, 8'h00});
        write_options(16'h003F);
        send_string('{8'h83, 8'h70, 8'h81, 8'h8F, 8'h81, 8'h20, 8'h81, 8'h05, 8'h81,
                      8'hFF, 8'h82, 8'h09, 8'h81, 8'h00});
    endtask

    task automatic test_random_strings();
        logic [15:0] settings[5];
        logic [7:0]  lead;
        settings = '{16'hFFFF, 16'h0000, 16'h7F00, 16'h00FF, 16'h0000};
        settings[4] = 16'($urandom);
        foreach (settings[s])
        begin
            write_options(settings[s]);
            for (int i = 0; i < 6; i++)
            begin
                if ($urandom_range(3, 0) == 0)
                begin
                    lead = ($urandom_range(1, 0) == 1) ? 8'($urandom_range('h83, 'h81))
                                                        : 8'($urandom_range('hFC, 'hE0));
                    send_byte(lead);
                    send_byte(($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 1))
                                                          : 8'($urandom_range('hFC, 'h40)));
                end
                else
                begin
                    send_byte(rand_byte());
                end
            end
            send_byte(8'h00);
        end
    endtask

    task automatic test_output_backpressure();
        write_options(16'h3F7F);
        stall.hold_long <= 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                stall.hold_long <= 1'b0;
            end
            for (int i = 0; i < 12; i++) send_byte(8'($urandom_range('hDD, 'hA6)));
        join
        send_byte(8'h00);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall.hold_long) dout.ready <= 1'b0;
            else dout.ready <= ($urandom_range(3, 0) != 0) || (cycles[9:8] == 2'b00);
        end
    end

    always @(posedge clk)
    begin
        word_t got;
        word_t want;
        if (rst_n && dout.valid && dout.ready)
        begin
            got = '{dout.out_byte, dout.string_end, dout.had_error, dout.last_of_run};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %p", got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("word mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("sjis_width_converter_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        timed_out              = 1'b0;
        mismatches             = 0;
        burst_left             = 0;
        rst_n                  = 1'b0;
        cfg.valid              = 1'b0;
        cfg.conversion_options = 16'h0000;
        din.valid              = 1'b0;
        din.in_byte            = 8'h00;
        dout.ready             = 1'b0;
        stall.hold_long        = 1'b0;
        opts_q                 = 16'h0000;
        pend_q                 = PEND_NONE;
        held_q                 = 8'h00;
        ctx_q                  = CTX_ASCII;
        err_q                  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_widen();
        test_directed_narrow();
        test_random_strings();
        test_output_backpressure();
        drain();
        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("sjis_width_converter_top regression: pass");
        end
        else
        begin
            $display("sjis_width_converter_top regression: fail");
        end
        $finish;
    end
endmodule
